### hw/rtl/text_page_line_wrapper_unit_assert.svh
// Assertion macros for the checker file.
`ifndef TEXT_PAGE_LINE_WRAPPER_UNIT_ASSERT_SVH
`define TEXT_PAGE_LINE_WRAPPER_UNIT_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define TPLW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tplw assertion failed");

// Next-cycle implication, quiet while reset is high.
`define TPLW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tplw assertion failed");

// Next-cycle implication that also holds across reset.
`define TPLW_ASSERT_RST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tplw assertion failed");

`endif

### hw/rtl/tplw_pkg.sv
package tplw_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_EOF   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_GLYPH = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_PAGE  = 2'd2,
    KIND_EOF   = 2'd3
  } kind_e;

  typedef enum logic {
    REG_LINE_WIDTH = 1'b0,
    REG_LINES_PAGE = 1'b1
  } reg_e;

  localparam logic [7:0]  LEAD_MIN      = 8'h81;
  localparam logic [7:0]  TRAIL_MIN     = 8'h40;
  localparam logic [7:0]  CHAR_CR       = 8'h0D;
  localparam logic [7:0]  CHAR_LF       = 8'h0A;
  localparam logic [11:0] WIDTH_RST     = 12'd296;
  localparam logic [3:0]  LINES_RST     = 4'd8;
  localparam logic [12:0] WIDE_PX       = 13'd16;
  localparam logic [12:0] NARROW_PX     = 13'd8;
  localparam logic [31:0] EOF_MARK      = 32'hFFFF_FFFF;
  localparam int          MaxRes        = 5;
  localparam int          ResIdxW       = 3;

endpackage

### hw/rtl/text_page_line_wrapper_unit.sv
// Results are registered: an item's results enter the result buffer when the item is taken.
// Throughput: one item per cycle while slot B is free; results leave one per cycle while
// out_ready is high, up to five per item, so the input stalls while slot B holds results.
// A two-slot result buffer lets the next item enter while results still drain.
// Reset: layout cleared, page idle until a start item, width 296 px, 8 lines per page,
// result buffer empty.
module text_page_line_wrapper_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  input  logic [31:0] page_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] glyph_code,
  output logic        glyph_wide,
  output logic [11:0] column_px,
  output logic [3:0]  row,
  output logic [31:0] next_offset,
  output logic        last
);

  typedef struct packed {
    tplw_pkg::kind_e kind;
    logic [15:0]     code;
    logic            wide;
    logic [11:0]     col;
    logic [3:0]      row;
    logic [31:0]     nxt;
  } res_t;

  typedef struct packed {
    logic [31:0] bpos;
    logic [11:0] col;
    logic [3:0]  lines;
    logic        pcr;
    logic        plead;
    logic [7:0]  lval;
    logic [31:0] lpos;
    logic        pfw;
    logic        done;
  } state_t;

  typedef struct packed {
    state_t                               s;
    logic                                 ended;
    logic [tplw_pkg::ResIdxW-1:0]         n;
    res_t [tplw_pkg::MaxRes-1:0]          r;
  } work_t;

  typedef struct packed {
    res_t [tplw_pkg::MaxRes-1:0]  r;
    logic [tplw_pkg::ResIdxW-1:0] cnt;
  } bundle_t;

  logic [11:0] line_width;
  logic [3:0]  lines_per_page;
  logic [3:0]  page_rows;
  state_t      st;
  work_t       w;

  bundle_t                      slot_a;
  bundle_t                      slot_b;
  logic                         a_valid;
  logic                         b_valid;
  logic [tplw_pkg::ResIdxW-1:0] idx;
  logic                         in_fire;
  logic                         push;
  logic                         a_last;
  logic                         a_done;
  res_t                         head;

  function automatic work_t emit_f(work_t wi, tplw_pkg::kind_e k, logic [15:0] code,
                                   logic wide, logic [11:0] col, logic [3:0] rw,
                                   logic [31:0] nxt);
    work_t o;
    o = wi;
    o.r[wi.n] = res_t'{kind: k, code: code, wide: wide, col: col, row: rw, nxt: nxt};
    o.n = wi.n + 1'b1;
    return o;
  endfunction

  // Only a line holding a glyph counts, and only while the page has room.
  function automatic work_t end_line_f(work_t wi, logic [3:0] pl);
    work_t o;
    o = wi;
    if (wi.s.col != 12'd0 && wi.s.lines < pl) begin
      o = emit_f(o, tplw_pkg::KIND_LINE, 16'd0, 1'b0, 12'd0, wi.s.lines, 32'd0);
      o.s.lines = wi.s.lines + 4'd1;
    end
    o.s.col = 12'd0;
    return o;
  endfunction

  function automatic work_t finish_f(work_t wi, logic [31:0] nxt);
    work_t o;
    o = emit_f(wi, tplw_pkg::KIND_PAGE, 16'd0, 1'b0, 12'd0, 4'd0, nxt);
    o.s.done  = 1'b1;
    o.s.pfw   = 1'b0;
    o.s.pcr   = 1'b0;
    o.s.plead = 1'b0;
    o.ended   = 1'b1;
    return o;
  endfunction

  function automatic work_t place_f(work_t wi, logic [15:0] code, logic wide,
                                    logic [31:0] off, logic [11:0] width, logic [3:0] pl);
    work_t       o;
    logic [12:0] wpx;
    o   = wi;
    wpx = wide ? tplw_pkg::WIDE_PX : tplw_pkg::NARROW_PX;
    if ({1'b0, wi.s.col} + wpx > {1'b0, width}) begin
      o = end_line_f(o, pl);
      if (o.s.lines >= pl) begin
        return finish_f(o, off);
      end
    end
    o = emit_f(o, tplw_pkg::KIND_GLYPH, code, wide, o.s.col, o.s.lines, 32'd0);
    o.s.col = o.s.col + wpx[11:0];
    return o;
  endfunction

  function automatic work_t plain_f(work_t wi, logic [7:0] b, logic [31:0] pos,
                                    logic [11:0] width, logic [3:0] pl);
    work_t o;
    o = wi;
    if (b == tplw_pkg::CHAR_CR) begin
      o = end_line_f(o, pl);
      if (o.s.lines >= pl) o.s.pfw = 1'b1;
      else o.s.pcr = 1'b1;
    end else if (b == tplw_pkg::CHAR_LF) begin
      o = end_line_f(o, pl);
      if (o.s.lines >= pl) o = finish_f(o, pos + 32'd1);
    end else if (b >= tplw_pkg::LEAD_MIN) begin
      o.s.plead = 1'b1;
      o.s.lval  = b;
      o.s.lpos  = pos;
    end else begin
      o = place_f(o, {8'd0, b}, 1'b0, pos, width, pl);
    end
    return o;
  endfunction

  assign page_rows = (lines_per_page == 4'd0) ? 4'd1 : lines_per_page;

  always_comb begin
    w       = '0;
    w.s     = st;
    unique case (cmd)
      tplw_pkg::CMD_START: begin
        w.s.bpos  = page_offset;
        w.s.col   = 12'd0;
        w.s.lines = 4'd0;
        w.s.pcr   = 1'b0;
        w.s.plead = 1'b0;
        w.s.lval  = 8'd0;
        w.s.lpos  = 32'd0;
        w.s.pfw   = 1'b0;
        w.s.done  = 1'b0;
      end
      tplw_pkg::CMD_DATA: begin
        if (!st.done) begin
          w.s.bpos = st.bpos + 32'd1;
          if (st.pfw) begin
            w = finish_f(w, (data_byte == tplw_pkg::CHAR_LF) ? st.bpos + 32'd1 : st.bpos);
          end else if (st.pcr) begin
            w.s.pcr = 1'b0;
            if (data_byte != tplw_pkg::CHAR_LF) begin
              w = plain_f(w, data_byte, st.bpos, line_width, page_rows);
            end
          end else if (st.plead) begin
            w.s.plead = 1'b0;
            if (data_byte >= tplw_pkg::TRAIL_MIN) begin
              w = place_f(w, {st.lval, data_byte}, 1'b1, st.lpos, line_width, page_rows);
            end else begin
              // invalid trail: lead goes out narrow, then the byte on its own
              w = place_f(w, {8'd0, st.lval}, 1'b0, st.lpos, line_width, page_rows);
              if (!w.ended) w = plain_f(w, data_byte, st.bpos, line_width, page_rows);
            end
          end else begin
            w = plain_f(w, data_byte, st.bpos, line_width, page_rows);
          end
        end
      end
      tplw_pkg::CMD_EOF: begin
        if (!st.done) begin
          if (!st.pfw) begin
            w.s.pcr = 1'b0;
            if (st.plead) begin
              w.s.plead = 1'b0;
              w = place_f(w, {8'd0, st.lval}, 1'b0, st.lpos, line_width, page_rows);
            end
            if (!w.ended) w = end_line_f(w, page_rows);
          end
          if (!w.ended) begin
            w = emit_f(w, tplw_pkg::KIND_EOF, 16'd0, 1'b0, 12'd0, 4'd0, tplw_pkg::EOF_MARK);
            w.s.done = 1'b1;
            w.s.pfw  = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready = !b_valid;
  assign in_fire  = in_valid && in_ready;
  assign push     = in_fire && (w.n != '0);
  assign a_last   = (idx == slot_a.cnt - 1'b1);
  assign a_done   = a_valid && out_ready && a_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width     <= tplw_pkg::WIDTH_RST;
      lines_per_page <= tplw_pkg::LINES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tplw_pkg::REG_LINE_WIDTH: line_width     <= cfg_data;
        tplw_pkg::REG_LINES_PAGE: lines_per_page <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{done: 1'b1, default: '0};
    end else if (in_fire) begin
      st <= w.s;
    end
  end

  // Slot A drains beat by beat; slot B holds the next item's results.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      idx     <= '0;
    end else begin
      if (a_valid && !a_done) begin
        if (out_ready) idx <= idx + 1'b1;
        if (push) b_valid <= 1'b1;
      end else if (b_valid) begin
        a_valid <= 1'b1;
        idx     <= '0;
        b_valid <= push;
      end else begin
        a_valid <= push;
        idx     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && !a_done) begin
      if (push) slot_b <= '{r: w.r, cnt: w.n};
    end else if (b_valid) begin
      slot_a <= slot_b;
      if (push) slot_b <= '{r: w.r, cnt: w.n};
    end else if (push) begin
      slot_a <= '{r: w.r, cnt: w.n};
    end
  end

  assign head        = slot_a.r[idx];
  assign out_valid   = a_valid;
  assign kind        = head.kind;
  assign glyph_code  = head.code;
  assign glyph_wide  = head.wide;
  assign column_px   = head.col;
  assign row         = head.row;
  assign next_offset = head.nxt;
  assign last        = a_last;

endmodule

### hw/rtl/tplw_checker.sv
`include "text_page_line_wrapper_unit_assert.svh"

module tplw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] glyph_code,
  input logic        glyph_wide,
  input logic [11:0] column_px,
  input logic [3:0]  row,
  input logic [31:0] next_offset,
  input logic        last
);

  // a held beat keeps its payload
  `TPLW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(kind) && $stable(glyph_code) && $stable(glyph_wide) &&
    $stable(column_px) && $stable(row) && $stable(next_offset) && $stable(last))

  // page end and end of file close the item's results
  `TPLW_ASSERT_IMP(a_end_last, out_valid && (kind == tplw_pkg::KIND_PAGE || kind == tplw_pkg::KIND_EOF), last)

  // input only backs up behind pending results
  `TPLW_ASSERT_IMP(a_stall_cause, !in_ready, out_valid)

  `TPLW_ASSERT_RST_NEXT(a_reset_empty, rst, in_ready && !out_valid)

endmodule

bind text_page_line_wrapper_unit tplw_checker u_tplw_checker (.*);
